/* hw/rtl/bpfs_pkg.sv */
`default_nettype none
package bpfs_pkg;

  // component width of packed vectors (default)
  localparam int COMPONENT_WIDTH_DEF = 16;

  // field widths
  localparam int FIELD_W   = 48;
  localparam int TEXEL_W   = 24;
  localparam int BYTE_W    = 8;
  localparam int CHAN_W    = 16;
  localparam int SHIN_W    = 8;
  localparam int IN_DATA_W = 2 * FIELD_W + 2 * TEXEL_W;
  localparam int OUT_DATA_W = 3 * CHAN_W;

  // unit vectors: signed Q1.14 in 16 bits
  localparam int UNIT_W    = 16;
  localparam int UNIT_FRAC = 14;
  localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << UNIT_FRAC);
  // half vector sum of two unit vectors
  localparam int HALF_IW   = UNIT_W + 1;

  // floor(y / 255) for y below 2^24: multiply by reciprocal, then one correction
  localparam int DIV_IN_W      = 24;
  localparam int DIV_MUL_W     = 17;
  localparam int DIV255_SHIFT  = 24;
  localparam logic [DIV_MUL_W-1:0] DIV255_MUL = DIV_MUL_W'((1 << DIV255_SHIFT) / 255);
  localparam logic [BYTE_W-1:0] TEX_WHITE = 8'hFF;
  localparam logic [CHAN_W-1:0] COLOR_MAX = 16'hFFFF;

  // register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CAMERA   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AMBIENT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIFFUSE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPECULAR = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHINE    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TEXTURE  = 3'd6;

  localparam logic [SHIN_W-1:0] SHINE_RESET = 8'd32;

  // lighting setup seen by the shading stage
  typedef struct packed {
    logic [FIELD_W-1:0] ambient;
    logic [FIELD_W-1:0] diffuse;
    logic [FIELD_W-1:0] specular;
    logic [SHIN_W-1:0]  shininess;
    logic               tex_en;
  } light_cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/blinn_phong_fragment_shade_top.sv */
// Blinn-Phong fragment shader, fully pipelined.
// Pipeline depth is set by the per-bit square-root and divider stages of the two
// normalize pipelines, each stage retiring one bit.
// Throughput: one fragment per cycle while the skid entry is empty; every stage
// takes a new fragment each cycle, and all stages hold while the skid entry is full.
// Reset: synchronous; clears all valid bits and loads register reset values
// (shininess 32, everything else 0).
`default_nettype none
module blinn_phong_fragment_shade_top #(
  parameter int COMPONENT_WIDTH = bpfs_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // world_position, surface_normal, diffuse_texel, specular_texel
  input  logic [bpfs_pkg::IN_DATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // color_red, color_green, color_blue
  output logic [bpfs_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bpfs_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [bpfs_pkg::FIELD_W-1:0] cfg_data
);
  import bpfs_pkg::*;

  localparam int CW   = COMPONENT_WIDTH;
  localparam int IW1  = CW + 1;
  localparam int PADW = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;
  localparam int PW1  = 2 * TEXEL_W;
  localparam int PW2  = 2 * TEXEL_W + 6 * UNIT_W;

  logic [FIELD_W-1:0] camera, light;
  light_cfg_t cfg;
  logic en;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera        <= '0;
      light         <= '0;
      cfg.ambient   <= '0;
      cfg.diffuse   <= '0;
      cfg.specular  <= '0;
      cfg.shininess <= SHINE_RESET;
      cfg.tex_en    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAMERA:   camera        <= cfg_data;
        REG_LIGHT:    light         <= cfg_data;
        REG_AMBIENT:  cfg.ambient   <= cfg_data;
        REG_DIFFUSE:  cfg.diffuse   <= cfg_data;
        REG_SPECULAR: cfg.specular  <= cfg_data;
        REG_SHINE:    cfg.shininess <= cfg_data[SHIN_W-1:0];
        REG_TEXTURE:  cfg.tex_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // raw vectors: normal, to light, to camera
  logic [PADW-1:0] wp, np, lp, cp;
  logic signed [IW1-1:0] vec1 [3][3];
  logic [CW-1:0] wc, nc, lc, cc;

  assign wp = PADW'(s_tdata[FIELD_W-1:0]);
  assign np = PADW'(s_tdata[2*FIELD_W-1:FIELD_W]);
  assign lp = PADW'(light);
  assign cp = PADW'(camera);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wc = wp[CW*c +: CW];
      nc = np[CW*c +: CW];
      lc = lp[CW*c +: CW];
      cc = cp[CW*c +: CW];
      vec1[0][c] = $signed({nc[CW-1], nc});
      vec1[1][c] = $signed({lc[CW-1], lc}) - $signed({wc[CW-1], wc});
      vec1[2][c] = $signed({cc[CW-1], cc}) - $signed({wc[CW-1], wc});
    end
  end

  assign s_tready = en;

  logic v1;
  logic signed [UNIT_W-1:0] u1 [3][3];
  logic [PW1-1:0] pass1;

  bpfs_norm #(.IW(IW1), .NV(3), .PW(PW1)) u_norm_nlv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .vec_in(vec1),
    .pass_in(s_tdata[IN_DATA_W-1:2*FIELD_W]),
    .out_valid(v1),
    .unit_out(u1),
    .pass_out(pass1)
  );

  // half vector from light and view units
  logic signed [HALF_IW-1:0] vec2 [1][3];
  logic [PW2-1:0] pass2_in, pass2;
  logic v2;
  logic signed [UNIT_W-1:0] u2 [1][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vec2[0][c] = HALF_IW'(u1[1][c]) + HALF_IW'(u1[2][c]);
    end
  end

  assign pass2_in = {pass1, u1[1][2], u1[1][1], u1[1][0], u1[0][2], u1[0][1], u1[0][0]};

  bpfs_norm #(.IW(HALF_IW), .NV(1), .PW(PW2)) u_norm_h (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1),
    .vec_in(vec2),
    .pass_in(pass2_in),
    .out_valid(v2),
    .unit_out(u2),
    .pass_out(pass2)
  );

  // unpack carried vectors
  logic signed [UNIT_W-1:0] n_u [3];
  logic signed [UNIT_W-1:0] l_u [3];
  logic signed [UNIT_W-1:0] h_u [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n_u[c] = $signed(pass2[UNIT_W*c +: UNIT_W]);
      l_u[c] = $signed(pass2[3*UNIT_W + UNIT_W*c +: UNIT_W]);
      h_u[c] = u2[0][c];
    end
  end

  bpfs_shade u_shade (
    .clk(clk), .rst(rst),
    .in_valid(v2),
    .n_unit(n_u),
    .l_unit(l_u),
    .h_unit(h_u),
    .diffuse_texel(pass2[6*UNIT_W +: TEXEL_W]),
    .specular_texel(pass2[6*UNIT_W + TEXEL_W +: TEXEL_W]),
    .cfg(cfg),
    .en(en),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire

/* hw/rtl/bpfs_norm.sv */
`default_nettype none
module bpfs_norm #(
  parameter int IW = 17,
  parameter int NV = 1,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [IW-1:0] vec_in [NV][3],
  input  logic [PW-1:0] pass_in,
  output logic out_valid,
  output logic signed [bpfs_pkg::UNIT_W-1:0] unit_out [NV][3],
  output logic [PW-1:0] pass_out
);
  import bpfs_pkg::*;

  localparam int SW  = 2 * IW + 8;    // radicand s << 8
  localparam int RW  = IW + 4;        // root width
  localparam int QW  = UNIT_FRAC;     // quotient bits below the saturation point
  localparam int PRE = 18 - UNIT_FRAC;
  localparam int SET = RW + 3;        // divider setup stage
  localparam int NS  = RW + QW + 5;

  logic vld [NS];
  logic [PW-1:0] pass [NS];
  logic sgn [NS-1][NV][3];
  logic [IW-1:0] mag [SET][NV][3];
  logic [2*IW-1:0] sq [NV][3];
  logic zero [2:NS-2][NV];

  // square root recurrence, index 0 is the radicand stage
  logic [SW-1:0] rx   [RW+1][NV];
  logic [RW+1:0] rem  [RW+1][NV];
  logic [RW-1:0] root [RW+1][NV];
  logic [SW-1:0] rx_n   [RW][NV];
  logic [RW+1:0] rem_n  [RW][NV];
  logic [RW-1:0] root_n [RW][NV];

  // division recurrence, index 0 is the setup stage
  logic [RW-1:0] dlen [QW+1][NV];
  logic          dsat [QW+1][NV][3];
  logic [RW-1:0] drem [QW+1][NV][3];
  logic [QW-1:0] dq   [QW+1][NV][3];
  logic [RW-1:0] drem_n [QW][NV][3];
  logic [QW-1:0] dq_n   [QW][NV][3];

  logic [2*IW-1:0] ssum [NV];

  // sum of squares
  always_comb begin
    for (int n = 0; n < NV; n++) begin
      ssum[n] = sq[n][0] + sq[n][1] + sq[n][2];
    end
  end

  // one root bit per stage
  always_comb begin
    logic [RW+1:0] cur;
    logic [RW+1:0] tr;
    for (int j = 0; j < RW; j++) begin
      for (int n = 0; n < NV; n++) begin
        cur = {rem[j][n][RW-1:0], rx[j][n][SW-1 -: 2]};
        tr  = {root[j][n], 2'b01};
        rx_n[j][n] = {rx[j][n][SW-3:0], 2'b00};
        if (cur >= tr) begin
          rem_n[j][n]  = cur - tr;
          root_n[j][n] = {root[j][n][RW-2:0], 1'b1};
        end else begin
          rem_n[j][n]  = cur;
          root_n[j][n] = {root[j][n][RW-2:0], 1'b0};
        end
      end
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [RW:0] r2;
    logic [RW:0] dl;
    for (int j = 0; j < QW; j++) begin
      for (int n = 0; n < NV; n++) begin
        for (int c = 0; c < 3; c++) begin
          r2 = {drem[j][n][c], 1'b0};
          dl = {1'b0, dlen[j][n]};
          if (r2 >= dl) begin
            drem_n[j][n][c] = RW'(r2 - dl);
            dq_n[j][n][c]   = {dq[j][n][c][QW-2:0], 1'b1};
          end else begin
            drem_n[j][n][c] = r2[RW-1:0];
            dq_n[j][n][c]   = {dq[j][n][c][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) vld[k] <= vld[k-1];
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      pass[0] <= pass_in;
      for (int k = 1; k < NS; k++) pass[k] <= pass[k-1];
      for (int k = 1; k < NS - 1; k++) sgn[k] <= sgn[k-1];
      for (int k = 1; k < SET; k++) mag[k] <= mag[k-1];
      for (int k = 3; k < NS - 1; k++) zero[k] <= zero[k-1];
      for (int n = 0; n < NV; n++) begin
        for (int c = 0; c < 3; c++) begin
          sgn[0][n][c] <= vec_in[n][c][IW-1];
          mag[0][n][c] <= vec_in[n][c][IW-1] ? IW'(-vec_in[n][c]) : IW'(vec_in[n][c]);
          sq[n][c]     <= (2*IW)'(mag[0][n][c]) * (2*IW)'(mag[0][n][c]);
        end
        rx[0][n]   <= {ssum[n], 8'b0};
        rem[0][n]  <= '0;
        root[0][n] <= '0;
        zero[2][n] <= (ssum[n] == '0);
      end
      for (int j = 0; j < RW; j++) begin
        rx[j+1]   <= rx_n[j];
        rem[j+1]  <= rem_n[j];
        root[j+1] <= root_n[j];
      end
      for (int n = 0; n < NV; n++) begin
        dlen[0][n] <= root[RW][n];
        for (int c = 0; c < 3; c++) begin
          dsat[0][n][c] <= {mag[SET-1][n][c], {PRE{1'b0}}} >= root[RW][n];
          drem[0][n][c] <= {mag[SET-1][n][c], {PRE{1'b0}}};
          dq[0][n][c]   <= '0;
        end
      end
      for (int j = 0; j < QW; j++) begin
        dlen[j+1] <= dlen[j];
        dsat[j+1] <= dsat[j];
        drem[j+1] <= drem_n[j];
        dq[j+1]   <= dq_n[j];
      end
      // saturate at one, restore sign, zero vector gives zero
      for (int n = 0; n < NV; n++) begin
        for (int c = 0; c < 3; c++) begin
          if (zero[NS-2][n]) begin
            unit_out[n][c] <= '0;
          end else if (dsat[QW][n][c]) begin
            unit_out[n][c] <= sgn[NS-2][n][c] ? -$signed(UNIT_ONE) : $signed(UNIT_ONE);
          end else if (sgn[NS-2][n][c]) begin
            unit_out[n][c] <= -$signed(UNIT_W'(dq[QW][n][c]));
          end else begin
            unit_out[n][c] <= $signed(UNIT_W'(dq[QW][n][c]));
          end
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign pass_out  = pass[NS-1];

endmodule
`default_nettype wire

/* hw/rtl/bpfs_shade.sv */
`default_nettype none
module bpfs_shade (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [bpfs_pkg::UNIT_W-1:0] n_unit [3],
  input  logic signed [bpfs_pkg::UNIT_W-1:0] l_unit [3],
  input  logic signed [bpfs_pkg::UNIT_W-1:0] h_unit [3],
  input  logic [bpfs_pkg::TEXEL_W-1:0] diffuse_texel,
  input  logic [bpfs_pkg::TEXEL_W-1:0] specular_texel,
  input  bpfs_pkg::light_cfg_t cfg,
  output logic en,
  output logic m_tvalid,
  input  logic m_tready,
  // color_red, color_green, color_blue
  output logic [bpfs_pkg::OUT_DATA_W-1:0] m_tdata
);
  import bpfs_pkg::*;

  localparam int DW  = UNIT_FRAC + 1;   // clamped dot width
  localparam int PS  = 2;               // first power stage
  localparam int C1  = PS + SHIN_W;
  localparam int NSH = C1 + 4;
  localparam int TW  = 2 * TEXEL_W;
  localparam int PW2 = 2 * DW;

  logic vld [NSH];
  logic [TW-1:0] tex [C1];
  logic signed [2*UNIT_W-1:0] pl [3];
  logic signed [2*UNIT_W-1:0] ph [3];
  logic [DW-1:0] nl [1:C1-1];
  logic [DW-1:0] nh;
  logic [DW-1:0] pr [SHIN_W];
  logic [DW-1:0] pb [SHIN_W-1];
  logic [DW-1:0] rprev [SHIN_W];
  logic [DW-1:0] bprev [SHIN_W];
  logic [PW2-1:0] rm [SHIN_W];
  logic [PW2-1:0] bm [SHIN_W];
  logic [DW-1:0] c1_nl, c1_pw;
  logic [DIV_IN_W-1:0] c1_at [3], c1_dt [3], c1_st [3];
  logic [DIV_IN_W-1:0] y2 [3][3];
  logic [DIV_IN_W-1:0] y3 [3][3];
  logic [CHAN_W-1:0] q3 [3][3];
  logic [CHAN_W-1:0] q4 [3][3];
  logic [DW-1:0] dot_l, dot_h;
  logic [CHAN_W-1:0] inc [3];
  logic [CHAN_W-1:0] out_r [3];
  logic [CHAN_W-1:0] skid_r [3];
  logic out_v, skid_v, arrive;

  // clamped dot products
  always_comb begin
    logic signed [2*UNIT_W+1:0] sl;
    logic signed [2*UNIT_W+1:0] sh;
    logic [2*UNIT_W+1-UNIT_FRAC:0] ql;
    logic [2*UNIT_W+1-UNIT_FRAC:0] qh;
    sl = (2*UNIT_W+2)'(pl[0]) + (2*UNIT_W+2)'(pl[1]) + (2*UNIT_W+2)'(pl[2]);
    sh = (2*UNIT_W+2)'(ph[0]) + (2*UNIT_W+2)'(ph[1]) + (2*UNIT_W+2)'(ph[2]);
    ql = sl[2*UNIT_W+1:UNIT_FRAC];
    qh = sh[2*UNIT_W+1:UNIT_FRAC];
    if (sl <= 0) dot_l = '0;
    else if (ql > (2*UNIT_W+2-UNIT_FRAC)'(UNIT_ONE)) dot_l = DW'(UNIT_ONE);
    else dot_l = ql[DW-1:0];
    if (sh <= 0) dot_h = '0;
    else if (qh > (2*UNIT_W+2-UNIT_FRAC)'(UNIT_ONE)) dot_h = DW'(UNIT_ONE);
    else dot_h = qh[DW-1:0];
  end

  // square and multiply, exponent bits from the bottom
  always_comb begin
    for (int k = 0; k < SHIN_W; k++) begin
      rprev[k] = (k == 0) ? DW'(UNIT_ONE) : pr[(k == 0) ? 0 : k-1];
      bprev[k] = (k == 0) ? nh : pb[(k == 0) ? 0 : k-1];
      rm[k] = PW2'(rprev[k]) * PW2'(bprev[k]);
      bm[k] = PW2'(bprev[k]) * PW2'(bprev[k]);
    end
  end

  // final sum with saturation
  always_comb begin
    logic [CHAN_W+1:0] s;
    for (int c = 0; c < 3; c++) begin
      s = (CHAN_W+2)'(q4[0][c]) + (CHAN_W+2)'(q4[1][c]) + (CHAN_W+2)'(q4[2][c]);
      inc[c] = (s > (CHAN_W+2)'(COLOR_MAX)) ? COLOR_MAX : s[CHAN_W-1:0];
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NSH; k++) vld[k] <= vld[k-1];
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    logic [BYTE_W-1:0] te;
    logic [BYTE_W-1:0] ts;
    logic [DIV_IN_W+DW-1:0] pd;
    logic [DIV_IN_W+DW-1:0] psp;
    logic [DIV_IN_W+DIV_MUL_W-1:0] pq;
    logic [DIV_IN_W-1:0] back;
    logic [DIV_IN_W-1:0] rr;
    if (en) begin
      tex[0] <= {specular_texel, diffuse_texel};
      for (int k = 1; k < C1; k++) tex[k] <= tex[k-1];
      for (int c = 0; c < 3; c++) begin
        pl[c] <= n_unit[c] * l_unit[c];
        ph[c] <= n_unit[c] * h_unit[c];
      end
      nl[1] <= dot_l;
      for (int k = 2; k < C1; k++) nl[k] <= nl[k-1];
      nh <= dot_h;
      for (int k = 0; k < SHIN_W; k++) begin
        pr[k] <= cfg.shininess[k] ? rm[k][UNIT_FRAC +: DW] : rprev[k];
      end
      for (int k = 0; k < SHIN_W - 1; k++) pb[k] <= bm[k][UNIT_FRAC +: DW];
      // light times texel
      c1_nl <= nl[C1-1];
      c1_pw <= pr[SHIN_W-1];
      for (int c = 0; c < 3; c++) begin
        te = cfg.tex_en ? tex[C1-1][BYTE_W*c +: BYTE_W] : TEX_WHITE;
        ts = cfg.tex_en ? tex[C1-1][TEXEL_W + BYTE_W*c +: BYTE_W] : TEX_WHITE;
        c1_at[c] <= DIV_IN_W'(cfg.ambient[CHAN_W*c +: CHAN_W]) * DIV_IN_W'(te);
        c1_dt[c] <= DIV_IN_W'(cfg.diffuse[CHAN_W*c +: CHAN_W]) * DIV_IN_W'(te);
        c1_st[c] <= DIV_IN_W'(cfg.specular[CHAN_W*c +: CHAN_W]) * DIV_IN_W'(ts);
      end
      // scale by dot and power
      for (int c = 0; c < 3; c++) begin
        pd  = (DIV_IN_W+DW)'(c1_dt[c]) * (DIV_IN_W+DW)'(c1_nl);
        psp = (DIV_IN_W+DW)'(c1_st[c]) * (DIV_IN_W+DW)'(c1_pw);
        y2[0][c] <= c1_at[c];
        y2[1][c] <= pd[UNIT_FRAC +: DIV_IN_W];
        y2[2][c] <= psp[UNIT_FRAC +: DIV_IN_W];
      end
      // divide by 255: reciprocal estimate, then one correction
      for (int t = 0; t < 3; t++) begin
        for (int c = 0; c < 3; c++) begin
          pq = (DIV_IN_W+DIV_MUL_W)'(y2[t][c]) * (DIV_IN_W+DIV_MUL_W)'(DIV255_MUL);
          q3[t][c] <= pq[DIV255_SHIFT +: CHAN_W];
          y3[t][c] <= y2[t][c];
          back = {q3[t][c], 8'b0} - DIV_IN_W'(q3[t][c]);
          rr   = y3[t][c] - back;
          q4[t][c] <= (rr >= DIV_IN_W'(TEX_WHITE)) ? q3[t][c] + 1'b1 : q3[t][c];
        end
      end
    end
  end

  // output register with skid entry
  assign en     = !skid_v;
  assign arrive = en && vld[NSH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      out_v  <= skid_v || arrive;
      skid_v <= 1'b0;
    end else if (arrive) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      out_r <= skid_v ? skid_r : inc;
    end else if (arrive) begin
      skid_r <= inc;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {out_r[2], out_r[1], out_r[0]};

  // skid entry only fills behind a stalled output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid holds data while output is empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_v && !m_tready && arrive) |=> skid_v)
    else $error("result arriving at stalled output was not kept");
  a_dot_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (nl[1] <= DW'(UNIT_ONE) && nh <= DW'(UNIT_ONE)))
    else $error("clamped dot product above one");
  a_pow_range: assert property (@(posedge clk) disable iff (rst)
    vld[C1] |-> (c1_pw <= DW'(UNIT_ONE)))
    else $error("specular power above one");

endmodule
`default_nettype wire

/* bench/tb_blinn_phong_fragment_shade_top.sv */
`timescale 1ns / 1ps
module tb_blinn_phong_fragment_shade_top;
  import bpfs_pkg::*;

  localparam int CW = COMPONENT_WIDTH_DEF;
  localparam int PIPE_LAT = CW + 79;
  localparam int STALL_LIMIT = 4000;
  localparam longint unsigned Q14_ONE = 64'd16384;
  // index past the last register
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef longint vec3_t [3];

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0] cfg_data;

  blinn_phong_fragment_shade_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the lighting registers
  logic [FIELD_W-1:0] cam_pos, light_pos, amb_col, dif_col, spec_col;
  logic [SHIN_W-1:0] shine;
  logic tex_on;

  logic [OUT_DATA_W-1:0] color_queue[$];
  int errors;
  int frags_sent;
  int colors_seen;
  int phases;
  int rx_mode;
  int idle_cycles;
  int cyc;

  // one directed fragment
  typedef struct {
    logic [FIELD_W-1:0] world;
    logic [FIELD_W-1:0] normal;
    logic [TEXEL_W-1:0] dtex;
    logic [TEXEL_W-1:0] stex;
    bit typed;
    logic [OUT_DATA_W-1:0] color;
  } frag_row_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint comp(logic [FIELD_W-1:0] p, int i);
    logic signed [CW-1:0] c;
    c = p[i*CW +: CW];
    return longint'(c);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v);
    vec3_t u;
    longint unsigned mag[3];
    longint unsigned s, len, q;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      s += mag[i] * mag[i];
    end
    if (s == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return u;
    end
    len = int_sqrt(s << 8);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 18) / len;
      if (q > Q14_ONE) q = Q14_ONE;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  function automatic longint unsigned pos_dot(vec3_t a, vec3_t b);
    longint s;
    longint unsigned q;
    s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (s <= 0) return 0;
    q = longint'(s) >>> 14;
    return (q > Q14_ONE) ? Q14_ONE : q;
  endfunction

  function automatic longint unsigned pow_q14(longint unsigned b, logic [SHIN_W-1:0] e);
    longint unsigned r;
    r = Q14_ONE;
    for (int i = 0; i < SHIN_W; i++) begin
      if (e[i]) r = (r * b) >> 14;
      b = (b * b) >> 14;
    end
    return r;
  endfunction

  // expected shaded colour of one fragment under the current registers
  function automatic logic [OUT_DATA_W-1:0] shade_color(logic [IN_DATA_W-1:0] d);
    logic [FIELD_W-1:0] world, normal;
    logic [TEXEL_W-1:0] dtex, stex;
    vec3_t nr, lr, vr, hr, n, l, v, h;
    longint unsigned ndl, ndh, sp, te, ts, a, df, sc, sum;
    logic [OUT_DATA_W-1:0] res;
    world = d[0 +: FIELD_W];
    normal = d[FIELD_W +: FIELD_W];
    dtex = d[2*FIELD_W +: TEXEL_W];
    stex = d[2*FIELD_W+TEXEL_W +: TEXEL_W];
    for (int i = 0; i < 3; i++) begin
      nr[i] = comp(normal, i);
      lr[i] = comp(light_pos, i) - comp(world, i);
      vr[i] = comp(cam_pos, i) - comp(world, i);
    end
    n = unit_vec(nr);
    l = unit_vec(lr);
    v = unit_vec(vr);
    for (int i = 0; i < 3; i++) hr[i] = l[i] + v[i];
    h = unit_vec(hr);
    ndl = pos_dot(n, l);
    ndh = pos_dot(n, h);
    sp = pow_q14(ndh, shine);
    for (int i = 0; i < 3; i++) begin
      te = tex_on ? dtex[8*i +: 8] : 64'd255;
      ts = tex_on ? stex[8*i +: 8] : 64'd255;
      a = amb_col[16*i +: 16];
      df = dif_col[16*i +: 16];
      sc = spec_col[16*i +: 16];
      sum = (a * te) / 255 + (df * te * ndl) / (255 * Q14_ONE)
          + (sc * ts * sp) / (255 * Q14_ONE);
      res[16*i +: 16] = (sum > 65535) ? 16'hFFFF : sum[15:0];
    end
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] rand48();
    return FIELD_W'({$urandom(), $urandom()});
  endfunction

  // small coordinates so the geometry stays meaningful
  function automatic logic [FIELD_W-1:0] rand_pos();
    logic [FIELD_W-1:0] p;
    for (int i = 0; i < 3; i++)
      p[i*CW +: CW] = CW'($urandom_range(0, 4096) - 2048);
    return p;
  endfunction

  // one register write; valid drops for a cycle before the next call
  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CAMERA:   cam_pos = val;
      REG_LIGHT:    light_pos = val;
      REG_AMBIENT:  amb_col = val;
      REG_DIFFUSE:  dif_col = val;
      REG_SPECULAR: spec_col = val;
      REG_SHINE:    shine = val[SHIN_W-1:0];
      REG_TEXTURE:  tex_on = val[0];
      default: ;
    endcase
  endtask

  // one fragment transaction; valid stays high for a following call
  task automatic send_frag(logic [IN_DATA_W-1:0] d, bit typed, logic [OUT_DATA_W-1:0] col);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    color_queue.push_back(typed ? col : shade_color(d));
    frags_sent++;
  endtask

  task automatic sender_gap();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // wait until the pipeline has drained before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
    phases++;
  endtask

  task automatic random_phase(int count, bit extreme);
    int burst;
    logic [IN_DATA_W-1:0] d;
    reg_write(REG_CAMERA, extreme ? rand48() : rand_pos());
    reg_write(REG_LIGHT, extreme ? rand48() : rand_pos());
    reg_write(REG_AMBIENT, extreme ? 48'hFFFF_FFFF_FFFF : rand48() & 48'h0FFF_0FFF_0FFF);
    reg_write(REG_DIFFUSE, extreme ? rand48() : rand48() & 48'h1FFF_1FFF_1FFF);
    reg_write(REG_SPECULAR, rand48());
    reg_write(REG_SHINE, FIELD_W'($urandom_range(0, 255)));
    reg_write(REG_TEXTURE, rand48());
    rx_mode = $urandom_range(0, 2);
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 3) == 0) sender_gap();
      end
      d[0 +: FIELD_W] = ($urandom_range(0, 4) == 0) ? rand48() : rand_pos();
      d[FIELD_W +: FIELD_W] = rand48();
      d[2*FIELD_W +: 2*TEXEL_W] = rand48();
      send_frag(d, 1'b0, '0);
      burst--;
    end
    drain();
  endtask

  // receiver stall pattern and result check
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    cyc <= cyc + 1;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      default: m_tready <= (cyc % 11) < 6;
    endcase
    if (!rst && m_tvalid && m_tready) begin
      colors_seen++;
      if (color_queue.size() == 0) begin
        $error("color with no expectation: %h", m_tdata);
        errors++;
      end else begin
        want = color_queue.pop_front();
        if (m_tdata[0 +: 16] !== want[0 +: 16]) begin
          $error("color_red expected %h actual %h", want[0 +: 16], m_tdata[0 +: 16]);
          errors++;
        end
        if (m_tdata[16 +: 16] !== want[16 +: 16]) begin
          $error("color_green expected %h actual %h", want[16 +: 16], m_tdata[16 +: 16]);
          errors++;
        end
        if (m_tdata[32 +: 16] !== want[32 +: 16]) begin
          $error("color_blue expected %h actual %h", want[32 +: 16], m_tdata[32 +: 16]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_blinn_phong_fragment_shade_top: done, errors");
      $finish;
    end
  end

  initial begin
    frag_row_t rows[$];
    frag_row_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    frags_sent = 0;
    colors_seen = 0;
    phases = 0;
    rx_mode = 0;
    idle_cycles = 0;
    cyc = 0;
    cam_pos = '0; light_pos = '0; amb_col = '0; dif_col = '0; spec_col = '0;
    shine = SHINE_RESET;
    tex_on = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: all light colours zero, so every colour is black
    rows = '{
      '{'0, '0, '0, '0, 1'b1, '0},
      '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '0},
      '{48'h0, 48'h0100_0000_0000, 24'h0, 24'h0, 1'b1, '0}
    };
    foreach (rows[i]) send_frag({rows[i].stex, rows[i].dtex, rows[i].normal, rows[i].world},
                                rows[i].typed, rows[i].color);
    drain();

    // camera and light straight above, white colours, textures on
    reg_write(REG_CAMERA, 48'h0400_0000_0000);
    reg_write(REG_LIGHT, 48'h0400_0000_0000);
    reg_write(REG_AMBIENT, 48'h0400_0400_0400);
    reg_write(REG_DIFFUSE, 48'h1000_1000_1000);
    reg_write(REG_SPECULAR, 48'h1000_1000_1000);
    reg_write(REG_TEXTURE, 48'h1);
    reg_write(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    rows = '{
      '{'0, 48'h0100_0000_0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{'0, 48'h0100_0000_0000, 24'h000000, 24'h000000, 1'b0, '0},
      '{'0, 48'h0, 24'h80FF01, 24'h01FF80, 1'b0, '0},
      '{'0, 48'hFF00_0000_0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{'0, 48'h8000_8000_8000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{'0, 48'h7FFF_7FFF_7FFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{48'h0400_0000_0000, 48'h0100_0000_0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{48'h0000_0100_0100, 48'h0100_0100_0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0}
    };
    foreach (rows[i]) send_frag({rows[i].stex, rows[i].dtex, rows[i].normal, rows[i].world},
                                rows[i].typed, rows[i].color);
    drain();

    // opposite light and view, shininess zero, saturating ambient
    reg_write(REG_LIGHT, 48'hFC00_0000_0000);
    reg_write(REG_SHINE, 48'h0);
    reg_write(REG_AMBIENT, 48'hFFFF_FFFF_FFFF);
    reg_write(REG_TEXTURE, 48'h0);
    r = '{'0, 48'h0100_0000_0000, 24'h0, 24'h0, 1'b1, 48'hFFFF_FFFF_FFFF};
    send_frag({r.stex, r.dtex, r.normal, r.world}, 1'b1, r.color);
    r = '{'0, 48'h0100_0100_0100, 24'h123456, 24'h654321, 1'b0, '0};
    send_frag({r.stex, r.dtex, r.normal, r.world}, 1'b0, '0);
    drain();

    // highest shininess, light beside the camera
    reg_write(REG_AMBIENT, 48'h0);
    reg_write(REG_LIGHT, 48'h0400_0000_0100);
    reg_write(REG_SHINE, 48'hFF);
    reg_write(REG_TEXTURE, 48'hFFFF_FFFF_FFFE);
    for (int i = 0; i < 4; i++) begin
      r = '{'0, {16'h0100, 16'h0, CW'(i * 16)}, 24'hFFFFFF, 24'hFF00FF, 1'b0, '0};
      send_frag({r.stex, r.dtex, r.normal, r.world}, 1'b0, '0);
    end
    drain();

    // random phases, two of them with extreme settings
    for (int p = 0; p < 8; p++) random_phase(105, (p == 3) || (p == 6));

    $display("covered %0d fragments in %0d register phases, %0d colors checked",
             frags_sent, phases, colors_seen);
    $display("stress: random stalls both sides, extreme registers, zero vectors, saturation");
    if (errors == 0) begin
      $display("tb_blinn_phong_fragment_shade_top: done, clean");
    end else begin
      $display("tb_blinn_phong_fragment_shade_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bpfs_pkg.sv
hw/rtl/bpfs_norm.sv
hw/rtl/bpfs_shade.sv
hw/rtl/blinn_phong_fragment_shade_top.sv
bench/tb_blinn_phong_fragment_shade_top.sv
